[sv/aapr_pkg.sv]
// Shared types, constants and the CORDIC angle table for the axis-angle rotation core.
// No dependencies; every other file imports this package.
package aapr_pkg;

  // Default build values handed to the top level
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Square root runs one result bit per stage, the divide one quotient bit per stage
  localparam int SQ_STEPS    = 32;
  localparam int DV_STEPS    = 31;
  localparam int FRONT_STEPS = SQ_STEPS + DV_STEPS;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [34:0] Q30_ONE         = 35'sd1073741824;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] angle_turn;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               axis_zero;
    logic               saturated;
  } out_req_t;

  // State carried by one request through the normalize / CORDIC pipeline
  typedef struct packed {
    logic signed [2:0][31:0] pt;
    logic        [2:0]       sgn;
    logic        [2:0][15:0] mag;
    logic                    zero;
    logic                    flip;
    logic signed [33:0]      cx;
    logic signed [33:0]      cy;
    logic signed [33:0]      cz;
    logic        [31:0]      d2;
    logic        [34:0]      sq_rem;
    logic        [31:0]      sq_root;
    logic        [2:0][32:0] dv_rem;
    logic        [2:0][30:0] dv_q;
  } lane_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [33:0] atan_turn(input int idx);
    logic signed [33:0] val;
    case (idx)
      0:  val = 34'sd536870912;
      1:  val = 34'sd316933406;
      2:  val = 34'sd167458907;
      3:  val = 34'sd85004756;
      4:  val = 34'sd42667331;
      5:  val = 34'sd21354465;
      6:  val = 34'sd10679838;
      7:  val = 34'sd5340245;
      8:  val = 34'sd2670163;
      9:  val = 34'sd1335087;
      10: val = 34'sd667544;
      11: val = 34'sd333772;
      12: val = 34'sd166886;
      13: val = 34'sd83443;
      14: val = 34'sd41722;
      15: val = 34'sd20861;
      16: val = 34'sd10430;
      17: val = 34'sd5215;
      18: val = 34'sd2608;
      19: val = 34'sd1304;
      20: val = 34'sd652;
      21: val = 34'sd326;
      22: val = 34'sd163;
      23: val = 34'sd81;
      default: val = 34'sd0;
    endcase
    return val;
  endfunction

endpackage

[sv/aapr_stage.sv]
// One stage of the front pipeline: square root bit, CORDIC micro-rotation, divide bit.
// Depends on aapr_pkg.
module aapr_stage import aapr_pkg::*; #(
  parameter int IDX           = 0,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  lane_t lane_i,
  output logic  vld_o,
  output lane_t lane_o
);

  lane_t lane_nxt;
  lane_t lane_r;
  logic  vld_r;
  logic [1:0] pair;

  // Radicand pairs come from d2; the low half of d2<<32 is zero
  generate
    if (IDX < SQ_STEPS / 2) begin : g_pair
      assign pair = lane_i.d2[31 - 2 * IDX -: 2];
    end else begin : g_nopair
      assign pair = 2'b00;
    end
  endgenerate

  // Compute this stage's step
  always_comb begin
    logic [34:0]        rem_sh;
    logic [34:0]        trial;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic [32:0]        rem_in;
    logic [32:0]        rem_sh2;
    logic [30:0]        q_in;
    lane_nxt = lane_i;
    rem_sh   = '0;
    trial    = '0;
    xs       = '0;
    ys       = '0;
    rem_in   = '0;
    rem_sh2  = '0;
    q_in     = '0;
    if (IDX < SQ_STEPS) begin
      rem_sh = {lane_i.sq_rem[32:0], pair};
      trial  = {1'b0, lane_i.sq_root, 2'b01};
      if (rem_sh >= trial) begin
        lane_nxt.sq_rem  = rem_sh - trial;
        lane_nxt.sq_root = {lane_i.sq_root[30:0], 1'b1};
      end else begin
        lane_nxt.sq_rem  = rem_sh;
        lane_nxt.sq_root = {lane_i.sq_root[30:0], 1'b0};
      end
    end
    if (IDX < CORDIC_STAGES) begin
      xs = lane_i.cx >>> IDX;
      ys = lane_i.cy >>> IDX;
      if (!lane_i.cz[33]) begin
        lane_nxt.cx = lane_i.cx - ys;
        lane_nxt.cy = lane_i.cy + xs;
        lane_nxt.cz = lane_i.cz - atan_turn(IDX);
      end else begin
        lane_nxt.cx = lane_i.cx + ys;
        lane_nxt.cy = lane_i.cy - xs;
        lane_nxt.cz = lane_i.cz + atan_turn(IDX);
      end
    end
    if (IDX >= SQ_STEPS) begin
      for (int k = 0; k < 3; k++) begin
        rem_in = (IDX == SQ_STEPS) ? {2'b00, lane_i.mag[k], 15'd0} : lane_i.dv_rem[k];
        q_in   = (IDX == SQ_STEPS) ? '0 : lane_i.dv_q[k];
        rem_sh2 = {rem_in[31:0], 1'b0};
        if (rem_sh2 >= {1'b0, lane_i.sq_root}) begin
          lane_nxt.dv_rem[k] = rem_sh2 - {1'b0, lane_i.sq_root};
          lane_nxt.dv_q[k]   = {q_in[29:0], 1'b1};
        end else begin
          lane_nxt.dv_rem[k] = rem_sh2;
          lane_nxt.dv_q[k]   = {q_in[29:0], 1'b0};
        end
      end
    end
  end

  // Advance valid under enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Advance payload under enable
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

[sv/axis_angle_point_rotation_core.sv]
// Top level: rotates a Q16.16 point about an integer axis by a fraction of a turn.
// Depends on aapr_pkg and aapr_stage.
//
//  channel | ports                      | direction | payload
//  in      | in_valid, in_stall, in_data | request in | point, axis, angle
//  out     | out_valid, out_stall, out_data | result out | rotated point, flags
//
// One request enters per cycle unless stalled; it passes an input stage, 32 square
// root stages (CORDIC runs alongside), 31 divide stages and 4 matrix stages.
// Throughput is set by the pipeline: one step per stage per cycle unless stalled.
// Reset clears only the valid bits. A stall at the output freezes every stage at
// once, so nothing is dropped or repeated; in_stall follows out_stall while a
// result is held.
module axis_angle_point_rotation_core import aapr_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------- input stage ----------------
  lane_t lane0_nxt;
  lane_t lane0_r;
  logic  vld0_r;

  // Form squared length, magnitudes and the folded CORDIC phase
  always_comb begin
    logic signed [31:0] sq [3];
    logic signed [15:0] ax [3];
    logic [31:0] phase;
    logic [31:0] phase_f;
    ax[0] = in_data.axis_x;
    ax[1] = in_data.axis_y;
    ax[2] = in_data.axis_z;
    lane0_nxt = '0;
    lane0_nxt.pt[0] = in_data.point_x;
    lane0_nxt.pt[1] = in_data.point_y;
    lane0_nxt.pt[2] = in_data.point_z;
    for (int k = 0; k < 3; k++) begin
      sq[k] = 32'(ax[k]) * 32'(ax[k]);
      lane0_nxt.sgn[k] = ax[k][15];
      lane0_nxt.mag[k] = ax[k][15] ? 16'(-ax[k]) : 16'(ax[k]);
    end
    lane0_nxt.d2   = 32'(sq[0]) + 32'(sq[1]) + 32'(sq[2]);
    lane0_nxt.zero = (lane0_nxt.d2 == 32'd0);
    phase = {in_data.angle_turn, 16'd0} & PH_MASK;
    lane0_nxt.flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    phase_f = lane0_nxt.flip ? phase + 32'h8000_0000 : phase;
    lane0_nxt.cz = 34'($signed(phase_f));
    lane0_nxt.cx = CORDIC_GAIN_Q30;
    lane0_nxt.cy = '0;
  end

  // Hold input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  // Capture input stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      lane0_r <= lane0_nxt;
    end
  end

  // ---------------- square root, CORDIC and divide ----------------
  lane_t lane_w [FRONT_STEPS + 1];
  logic  vld_w  [FRONT_STEPS + 1];

  assign lane_w[0] = lane0_r;
  assign vld_w[0]  = vld0_r;

  generate
    for (genvar g = 0; g < FRONT_STEPS; g++) begin : g_front
      aapr_stage #(
        .IDX           (g),
        .CORDIC_STAGES (CORDIC_STAGES)
      ) u_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (vld_w[g]),
        .lane_i (lane_w[g]),
        .vld_o  (vld_w[g + 1]),
        .lane_o (lane_w[g + 1])
      );
    end
  endgenerate

  lane_t lf;
  assign lf = lane_w[FRONT_STEPS];

  // ---------------- matrix stage 1: u_i*u_j and s*u_k ----------------
  logic signed [31:0] uu_r  [3][3];
  logic signed [33:0] su_r  [3];
  logic signed [33:0] c1_r;
  logic signed [34:0] omc1_r;
  logic signed [31:0] pt1_r [3];
  logic               zero1_r;
  logic               vld1_r;

  logic signed [31:0] uu_nxt [3][3];
  logic signed [33:0] su_nxt [3];
  logic signed [33:0] c_nxt;
  logic signed [33:0] s_nxt;

  // Sign the quotients and form the unit-vector products
  always_comb begin
    logic signed [31:0] uv [3];
    logic signed [63:0] p_uu;
    logic signed [67:0] p_su;
    for (int i = 0; i < 3; i++) begin
      uv[i] = lf.sgn[i] ? -$signed({1'b0, lf.dv_q[i]}) : $signed({1'b0, lf.dv_q[i]});
    end
    c_nxt = lf.flip ? -lf.cx : lf.cx;
    s_nxt = lf.flip ? -lf.cy : lf.cy;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_uu = 64'(uv[i]) * 64'(uv[j]);
        uu_nxt[i][j] = p_uu[61:30];
      end
      p_su = 68'(s_nxt) * 68'(uv[i]);
      su_nxt[i] = p_su[63:30];
    end
  end

  // Hold stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_w[FRONT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r    <= uu_nxt;
      su_r    <= su_nxt;
      c1_r    <= c_nxt;
      omc1_r  <= Q30_ONE - 35'(c_nxt);
      for (int k = 0; k < 3; k++) begin
        pt1_r[k] <= lf.pt[k];
      end
      zero1_r <= lf.zero;
    end
  end

  // ---------------- matrix stage 2: rotation matrix entries ----------------
  logic signed [35:0] r_r   [3][3];
  logic signed [35:0] r_nxt [3][3];
  logic signed [31:0] pt2_r [3];
  logic               zero2_r;
  logic               vld2_r;

  // Form R = c*I + (1-c)*u*u^T + s*[u]x
  always_comb begin
    logic signed [66:0] p_m;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_m = 67'(omc1_r) * 67'(uu_r[i][j]);
        r_nxt[i][j] = p_m[65:30] + ((i == j) ? 36'(c1_r) : 36'sd0);
      end
    end
    r_nxt[0][1] = r_nxt[0][1] - 36'(su_r[2]);
    r_nxt[0][2] = r_nxt[0][2] + 36'(su_r[1]);
    r_nxt[1][0] = r_nxt[1][0] + 36'(su_r[2]);
    r_nxt[1][2] = r_nxt[1][2] - 36'(su_r[0]);
    r_nxt[2][0] = r_nxt[2][0] - 36'(su_r[1]);
    r_nxt[2][1] = r_nxt[2][1] + 36'(su_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r     <= r_nxt;
      pt2_r   <= pt1_r;
      zero2_r <= zero1_r;
    end
  end

  // ---------------- matrix stage 3: rounded products ----------------
  logic signed [37:0] pr_r   [3][3];
  logic signed [37:0] pr_nxt [3][3];
  logic signed [31:0] pt3_r  [3];
  logic               zero3_r;
  logic               vld3_r;

  // Round each R_ij*p_j half up to Q16.16
  always_comb begin
    logic signed [67:0] p_rp;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_rp = 68'(r_r[i][j]) * 68'(pt2_r[j]) + 68'sd536870912;
        pr_nxt[i][j] = p_rp[67:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r    <= pr_nxt;
      pt3_r   <= pt2_r;
      zero3_r <= zero2_r;
    end
  end

  // ---------------- output stage: sum, clip, zero-axis bypass ----------------
  out_req_t out_nxt;
  out_req_t out_data_r;
  logic     out_valid_r;

  always_comb begin
    logic signed [39:0] acc;
    logic signed [31:0] rv [3];
    logic               sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 40'(pr_r[i][0]) + 40'(pr_r[i][1]) + 40'(pr_r[i][2]);
      if (acc > 40'sd2147483647) begin
        rv[i] = 32'sh7FFF_FFFF;
        sat   = 1'b1;
      end else if (acc < -40'sd2147483648) begin
        rv[i] = 32'sh8000_0000;
        sat   = 1'b1;
      end else begin
        rv[i] = acc[31:0];
      end
    end
    if (zero3_r) begin
      out_nxt.rot_x     = pt3_r[0];
      out_nxt.rot_y     = pt3_r[1];
      out_nxt.rot_z     = pt3_r[2];
      out_nxt.axis_zero = 1'b1;
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.rot_x     = rv[0];
      out_nxt.rot_y     = rv[1];
      out_nxt.rot_z     = rv[2];
      out_nxt.axis_zero = 1'b0;
      out_nxt.saturated = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track held result");

  a_zero_unsat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.axis_zero) |-> !out_data.saturated)
    else $error("zero axis result flagged saturated");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.rot_x == 32'sh7FFF_FFFF || out_data.rot_x == 32'sh8000_0000 ||
       out_data.rot_y == 32'sh7FFF_FFFF || out_data.rot_y == 32'sh8000_0000 ||
       out_data.rot_z == 32'sh7FFF_FFFF || out_data.rot_z == 32'sh8000_0000))
    else $error("saturated flag without a clipped component");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (vld3_r && out_valid && out_stall) |=> vld3_r)
    else $error("pipeline stage lost a request during stall");

endmodule
